@@ rtl/bls_pkg.sv @@
// Shared types and constants for the bounded LIFO stack.
`timescale 1ns / 1ps

package bls_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CAP_W         = 5;
   localparam int WORD_W        = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_DUMP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

@@ rtl/bls_if.sv @@
// Valid/ready channel interfaces for stack requests and responses.
`timescale 1ns / 1ps

interface bls_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        op;
   logic signed [bls_pkg::WORD_W-1:0] push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface bls_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic signed [bls_pkg::WORD_W-1:0] value;
   logic                              last;

   modport source (output valid, output status, output value, output last, input ready);
   modport sink   (input valid, input status, input value, input last, output ready);
endinterface

@@ rtl/bounded_lifo_stack.sv @@
// Top level of the bounded LIFO stack: control, entry count and response register.
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words held in a synchronous RAM. A push
// writes the RAM; a pop or peek goes through the read state, as the RAM returns
// read data in the cycle after the address; a dump reads the entries bottom up,
// one RAM read per entry. Refusals need no RAM read. The response sits in an
// output register, so a new request is taken in the cycle the previous response
// transfers. csr_wr_data sets the usable capacity; 0 acts as 1 and values above
// DEPTH act as DEPTH. Lowering it below the current count only blocks pushes.

module bounded_lifo_stack #(
   parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   bls_req_if.sink                   req_ch,
   bls_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [bls_pkg::CAP_W-1:0] csr_wr_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > bls_pkg::CAP_W) ? CNT_W : bls_pkg::CAP_W;

   bls_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [ADDR_W-1:0]            idx_ff, idx_in;
   logic                         dump_ff, dump_in;
   logic [bls_pkg::CAP_W-1:0]    cap_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   bls_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [bls_pkg::WORD_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         wr_en, rd_en;
   logic [ADDR_W-1:0]            wr_addr, rd_addr, top_addr;
   logic [bls_pkg::WORD_W-1:0]   rd_data;

   logic                         out_free, req_xfer, full, dump_last;
   logic [bls_pkg::CAP_W-1:0]    cap_nz;
   bls_pkg::op_type              req_op;

   bls_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign req_op    = bls_pkg::op_type'(req_ch.op);
   assign cap_nz    = (cap_ff == '0) ? bls_pkg::CAP_W'(1) : cap_ff;
   assign full      = (CMP_W'(count_ff) >= CMP_W'(DEPTH)) ||
                      (CMP_W'(count_ff) >= CMP_W'(cap_nz));
   assign top_addr  = ADDR_W'(count_ff - CNT_W'(1));
   assign wr_addr   = ADDR_W'(count_ff);
   assign dump_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bls_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bls_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      dump_ff       <= dump_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      dump_in       = dump_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = top_addr;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         bls_pkg::ST_IDLE: begin
            req_ch.ready = out_free;
            if (req_ch.valid && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               if (req_op == bls_pkg::OP_PUSH) begin
                  if (full) begin
                     rsp_status_in = bls_pkg::STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_status_in = bls_pkg::STATUS_OK;
                  end
               end else if (count_ff == '0) begin
                  rsp_status_in = bls_pkg::STATUS_EMPTY;
               end else begin
                  // response comes from the RAM read data in the read state
                  rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                  rsp_status_in = rsp_status_ff;
                  rsp_value_in  = rsp_value_ff;
                  rsp_last_in   = rsp_last_ff;
                  rd_en         = 1'b1;
                  idx_in        = '0;
                  dump_in       = (req_op == bls_pkg::OP_DUMP);
                  if (req_op == bls_pkg::OP_DUMP) begin
                     rd_addr = '0;
                  end
                  if (req_op == bls_pkg::OP_POP) begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  state_in = bls_pkg::ST_READ;
               end
            end
         end
         bls_pkg::ST_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bls_pkg::STATUS_OK;
               rsp_value_in  = rd_data;
               rsp_last_in   = !dump_ff || dump_last;
               if (dump_ff && !dump_last) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + ADDR_W'(1);
                  idx_in  = idx_ff + ADDR_W'(1);
               end else begin
                  state_in = bls_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bls_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.last   = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above depth");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_op == bls_pkg::OP_POP && count_ff != '0
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not remove one entry");

   a_push_inc: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_op == bls_pkg::OP_PUSH && !full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not add one entry");

   a_refuse_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != bls_pkg::STATUS_OK |-> rsp_last_ff)
      else $error("refusal not marked last");

   a_dump_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == bls_pkg::ST_READ && dump_ff |-> CNT_W'(idx_ff) < count_ff)
      else $error("dump index past stored entries");

endmodule

@@ rtl/bls_ram.sv @@
// Single-port-write, single-port-read word store with registered read data.
`timescale 1ns / 1ps

module bls_ram #(
   parameter int DEPTH = bls_pkg::DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [bls_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [bls_pkg::WORD_W-1:0] rd_data
);

   logic [bls_pkg::WORD_W-1:0] mem [DEPTH];
   logic [bls_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read, so a stalled response can wait on it
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
